### rtl/binary_to_decimal_ascii_macros.svh
// Assertion macros used by the converter back end (btda_back).
// Each macro takes a label, the clock, the active-low reset and the terms to check.
`ifndef BINARY_TO_DECIMAL_ASCII_MACROS_SVH
`define BINARY_TO_DECIMAL_ASCII_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define BTDA_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication
`define BTDA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define BTDA_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define BTDA_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### rtl/btda_pkg.sv
`timescale 1ns / 1ps

package btda_pkg;

	// Output character width and the ASCII codes of '0' and '9'
	localparam int DIGIT_W = 6;
	localparam logic [DIGIT_W-1:0] ASCII_ZERO = 6'd48;
	localparam logic [DIGIT_W-1:0] ASCII_NINE = 6'd57;

	// Width of one BCD digit
	localparam int BCD_W = 4;

	// Control handed from the front queue to the converter
	typedef struct packed {
		logic valid;
		logic is_zero;
	} job_ctl_t;

endpackage

### rtl/btda_front.sv
`timescale 1ns / 1ps

// Front end: takes items, flags zero values, and queues them for the converter.
module btda_front #(
	parameter int VALUE_WIDTH = 31
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [VALUE_WIDTH-1:0]    value,
	output btda_pkg::job_ctl_t        job_ctl,
	output logic [VALUE_WIDTH-1:0]    job_value,
	input  logic                      job_ready
);

	localparam int QDEPTH = 2;
	localparam int PTR_W  = 1;
	localparam int CNT_W  = 2;

	logic [VALUE_WIDTH-1:0] val_mem_q  [QDEPTH];
	logic                   zero_mem_q [QDEPTH];
	logic [PTR_W-1:0]       wr_ptr_q;
	logic [PTR_W-1:0]       rd_ptr_q;
	logic [CNT_W-1:0]       count_q;
	logic                   push;
	logic                   pop;

	assign in_ready = (count_q != CNT_W'(QDEPTH));
	assign push     = in_valid && in_ready;
	assign pop      = job_ctl.valid && job_ready;

	// Queue storage, classified on entry
	always_ff @(posedge clk) begin
		if (push) begin
			val_mem_q[wr_ptr_q]  <= value;
			zero_mem_q[wr_ptr_q] <= (value == '0);
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// Head of the queue
	assign job_ctl.valid   = (count_q != '0);
	assign job_ctl.is_zero = zero_mem_q[rd_ptr_q];
	assign job_value       = val_mem_q[rd_ptr_q];

endmodule

### rtl/btda_back.sv
`timescale 1ns / 1ps

`include "binary_to_decimal_ascii_macros.svh"

// Back end: shift-and-add-3 conversion, one value bit per cycle, then
// digit emission most significant first with leading zeros dropped.
module btda_back #(
	parameter int VALUE_WIDTH = 31
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  btda_pkg::job_ctl_t              job_ctl,
	input  logic [VALUE_WIDTH-1:0]          job_value,
	output logic                            job_ready,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [btda_pkg::DIGIT_W-1:0]    digit_char,
	output logic                            last
);

	// Digits needed for the widest value: floor(W * log10(2)) + 1
	localparam int NDIG  = (VALUE_WIDTH * 30103) / 100000 + 1;
	localparam int BCD_TOT = NDIG * btda_pkg::BCD_W;
	localparam int IDX_W = (NDIG > 1) ? $clog2(NDIG) : 1;
	localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_CONV = 2'd1;
	localparam logic [1:0] S_EMIT = 2'd2;

	logic [1:0]                      state_q;
	logic [VALUE_WIDTH-1:0]          shreg_q;
	logic [BCD_TOT-1:0]              bcd_q;
	logic [BCD_TOT-1:0]              bcd_adj;
	logic [CNT_W-1:0]                bit_cnt_q;
	logic [IDX_W-1:0]                dig_idx_q;
	logic                            started_q;
	logic                            out_valid_q;
	logic [btda_pkg::DIGIT_W-1:0]    digit_q;
	logic                            last_q;
	logic [btda_pkg::BCD_W-1:0]      cur_digit;
	logic                            is_last_dig;
	logic                            slot_free;
	logic                            skip_dig;
	logic                            load_out;
	logic                            job_take;

	assign job_ready = (state_q == S_IDLE);
	assign job_take  = job_ctl.valid && job_ready;
	assign slot_free = !out_valid_q || out_ready;

	// Add 3 to every BCD digit of 5 or more before the shift
	always_comb begin
		bcd_adj = bcd_q;
		for (int i = 0; i < NDIG; i++) begin
			if (bcd_q[i*btda_pkg::BCD_W +: btda_pkg::BCD_W] >= 4'd5) begin
				bcd_adj[i*btda_pkg::BCD_W +: btda_pkg::BCD_W] =
					bcd_q[i*btda_pkg::BCD_W +: btda_pkg::BCD_W] + 4'd3;
			end
		end
	end

	// Digit under the emit pointer
	assign cur_digit   = btda_pkg::BCD_W'(bcd_q >> {dig_idx_q, 2'b00});
	assign is_last_dig = (dig_idx_q == '0);
	assign skip_dig    = (state_q == S_EMIT) && !started_q && !is_last_dig
		&& (cur_digit == '0);
	assign load_out    = (state_q == S_EMIT) && !skip_dig && slot_free;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			bit_cnt_q <= '0;
			dig_idx_q <= '0;
			started_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (job_take) begin
						started_q <= 1'b0;
						if (job_ctl.is_zero) begin
							dig_idx_q <= '0;
							state_q   <= S_EMIT;
						end else begin
							bit_cnt_q <= CNT_W'(VALUE_WIDTH);
							state_q   <= S_CONV;
						end
					end
				end
				S_CONV: begin
					bit_cnt_q <= bit_cnt_q - CNT_W'(1);
					if (bit_cnt_q == CNT_W'(1)) begin
						dig_idx_q <= IDX_W'(NDIG - 1);
						state_q   <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (skip_dig) begin
						dig_idx_q <= dig_idx_q - IDX_W'(1);
					end else if (load_out) begin
						started_q <= 1'b1;
						if (is_last_dig) begin
							state_q <= S_IDLE;
						end else begin
							dig_idx_q <= dig_idx_q - IDX_W'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Conversion datapath
	always_ff @(posedge clk) begin
		if (job_take) begin
			shreg_q <= job_value;
			bcd_q   <= '0;
		end else if (state_q == S_CONV) begin
			shreg_q <= {shreg_q[VALUE_WIDTH-2:0], 1'b0};
			bcd_q   <= {bcd_adj[BCD_TOT-2:0], shreg_q[VALUE_WIDTH-1]};
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			digit_q <= btda_pkg::ASCII_ZERO + btda_pkg::DIGIT_W'(cur_digit);
			last_q  <= is_last_dig;
		end
	end

	assign out_valid  = out_valid_q;
	assign digit_char = digit_q;
	assign last       = last_q;

	`BTDA_ASSERT_NEXT(a_take_leaves_idle, clk, arst_n, job_take, state_q != S_IDLE)
	`BTDA_ASSERT_IMPLIES(a_conv_count_live, clk, arst_n, state_q == S_CONV, bit_cnt_q != '0)
	`BTDA_ASSERT_IMPLIES(a_no_lead_zero, clk, arst_n, load_out && !started_q, (cur_digit != '0) || is_last_dig)
	`BTDA_ASSERT_IMPLIES(a_digit_range, clk, arst_n, out_valid_q, (digit_q >= btda_pkg::ASCII_ZERO) && (digit_q <= btda_pkg::ASCII_NINE))

endmodule

### rtl/binary_to_decimal_ascii.sv
// Flow: an accepted nonzero value is shifted in over all VALUE_WIDTH bits, then its digit positions
// (10 at the default width) are emitted most significant first, with leading zero positions skipped
// (up to 9 at the default width); zero skips the shifting and goes straight to emitting '0'. The
// converter holds one item until its last digit is loaded into the output register, output stalls
// included; a two-entry queue keeps taking items while the converter is busy, until it is full.
// Reset (arst_n low, asynchronous) empties the queue, idles the converter, drops out_valid.
`timescale 1ns / 1ps

module binary_to_decimal_ascii #(
	parameter int VALUE_WIDTH = 31
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [VALUE_WIDTH-1:0]          value,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [btda_pkg::DIGIT_W-1:0]    digit_char,
	output logic                            last
);

	btda_pkg::job_ctl_t     job_ctl;
	logic [VALUE_WIDTH-1:0] job_value;
	logic                   job_ready;

	// Accept and queue
	btda_front #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.value     (value),
		.job_ctl   (job_ctl),
		.job_value (job_value),
		.job_ready (job_ready)
	);

	// Convert and emit
	btda_back #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_ctl    (job_ctl),
		.job_value  (job_value),
		.job_ready  (job_ready),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.digit_char (digit_char),
		.last       (last)
	);

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

	localparam int VALUE_WIDTH = 31;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 80;
	localparam int RANDOM_ITEMS = 330;

	// corner values: zero, single digits, digit-count boundaries, full scale, bit patterns
	localparam logic [VALUE_WIDTH-1:0] CORNER_VALUES [20] = '{
		31'd0, 31'd1, 31'd9, 31'd10, 31'd11, 31'd99, 31'd100, 31'd12345,
		31'd999999999, 31'd1000000000, 31'd1000000001, 31'd2147483647,
		31'd2147483646, 31'd1073741824, 31'd1431655765, 31'd715827882,
		31'd1999999999, 31'd2000000000, 31'd65536, 31'd3
	};

	typedef struct packed {
		logic [btda_pkg::DIGIT_W-1:0] code;
		logic                         last;
	} digit_item_t;

	// Holds the digit runs still owed by the block, oldest first
	class digit_scoreboard;
		digit_item_t pending_digits[$];
		int unsigned mismatches;

		function new();
			mismatches = 0;
		endfunction

		task report(input string msg);
			$display("mismatch: %s", msg);
			mismatches++;
		endtask

		// Decimal expansion of one accepted value, most significant digit first
		function void note_value(input logic [VALUE_WIDTH-1:0] v);
			int unsigned rest;
			logic [btda_pkg::DIGIT_W-1:0] rev[$];
			digit_item_t d;
			rest = v;
			do begin
				rev.push_back(btda_pkg::ASCII_ZERO + btda_pkg::DIGIT_W'(rest % 10));
				rest = rest / 10;
			end while (rest != 0);
			while (rev.size() > 0) begin
				d.code = rev.pop_back();
				d.last = (rev.size() == 0);
				pending_digits.push_back(d);
			end
		endfunction

		task check_digit(input logic [btda_pkg::DIGIT_W-1:0] code, input logic last);
			digit_item_t exp_d;
			if (pending_digits.size() == 0) begin
				report($sformatf("unexpected digit 0x%0h last=%0b", code, last));
			end else begin
				exp_d = pending_digits.pop_front();
				if (code !== exp_d.code)
					report($sformatf("digit_char 0x%0h, expected 0x%0h", code, exp_d.code));
				if (last !== exp_d.last)
					report($sformatf("last %0b, expected %0b", last, exp_d.last));
			end
		endtask

		function int unsigned outstanding();
			return pending_digits.size();
		endfunction
	endclass

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         in_valid;
	logic                         in_ready;
	logic [VALUE_WIDTH-1:0]       value;
	logic                         out_valid;
	logic                         out_ready;
	logic [btda_pkg::DIGIT_W-1:0] digit_char;
	logic                         last;

	// pacing controls: no_idle for sender and receiver, long_hold for the receiver
	bit no_idle = 1'b0;
	bit long_hold = 1'b0;

	digit_scoreboard sb = new();

	binary_to_decimal_ascii #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.digit_char(digit_char),
		.last      (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Offer one value after a random gap (none while no_idle is set); returns once the block takes it
	task send_value(input logic [VALUE_WIDTH-1:0] v);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		value    <= v;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_value(v);
	endtask

	// Random value with a random bit length, so every digit count shows up
	function logic [VALUE_WIDTH-1:0] random_value();
		int unsigned nbits;
		logic [31:0] r;
		nbits = $urandom_range(1, VALUE_WIDTH);
		r = $urandom;
		if ($urandom_range(0, 3) == 0)
			return r[VALUE_WIDTH-1:0];
		return VALUE_WIDTH'(r & ((32'h1 << nbits) - 1));
	endfunction

	// Receiver: random stall before each digit (none while no_idle is set), one long hold on request
	initial begin
		int stall;
		out_ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (long_hold) begin
				long_hold = 1'b0;
				stall = HOLD_CYCLES;
			end else begin
				stall = no_idle ? 0 : $urandom_range(0, 10);
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			sb.check_digit(digit_char, last);
		end
	end

	// Main sequence
	initial begin
		in_valid <= 1'b0;
		value    <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (CORNER_VALUES[i])
			send_value(CORNER_VALUES[i]);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// back-to-back stretch on both sides
			no_idle = (n >= 110 && n < 170);
			// receiver holds off while the sender keeps offering
			if (n == 200)
				long_hold = 1'b1;
			if (n >= 200 && n < 240)
				no_idle = 1'b1;
			send_value(random_value());
			if (n == 239)
				no_idle = 1'b0;
		end
		in_valid <= 1'b0;

		while (sb.outstanding() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// Watchdog
	initial begin
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule

### filelist.f
+incdir+rtl
rtl/btda_pkg.sv
rtl/btda_front.sv
rtl/btda_back.sv
rtl/binary_to_decimal_ascii.sv
tb/sv/testbench.sv
